// ----- hdl/mct_pkg.sv -----
// Shared types, codes and the microcode table of the March C test controller.
package mct_pkg;

    localparam logic [7:0] PAT_ZERO = 8'h00;
    localparam logic [7:0] PAT_ONES = 8'hFF;

    // Configuration register indexes
    localparam logic [1:0] CFG_BASE_ADDRESS  = 2'd0;
    localparam logic [1:0] CFG_REGION_LENGTH = 2'd1;
    localparam logic [1:0] CFG_SAVE_RESTORE  = 2'd2;

    typedef enum logic [3:0] {
        STEP_IDLE    = 4'd0,
        STEP_SAVE    = 4'd1,
        STEP_M0      = 4'd2,
        STEP_M1      = 4'd3,
        STEP_M2      = 4'd4,
        STEP_M3      = 4'd5,
        STEP_M4      = 4'd6,
        STEP_M5      = 4'd7,
        STEP_RESTORE = 4'd8,
        STEP_FINISH  = 4'd9
    } t_step;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } t_op;

    // One control word per step
    typedef struct packed {
        t_op        op;          // access issued by the step
        logic       use_buf;     // write data comes from the save buffer
        logic [7:0] wdata;       // write pattern (also the read-modify-write pattern)
        logic [7:0] expected;    // pattern a read must return
        logic       rmw;         // a returned read is followed by a write
        logic       capture;     // a returned read goes into the save buffer
        logic       desc;        // walk the region downward
        t_step      next;        // step entered at the end of the region
        t_step      alt;         // jump target when restore is disabled
        logic       alt_no_save; // take alt when the run does not save
    } t_ctrl;

    typedef struct packed {
        logic [15:0] base_address;
        logic [8:0]  region_length;
        logic        save_restore;
    } t_cfg;

    typedef struct packed {
        logic       start_req;
        logic [7:0] read_data;
    } t_in_item;

    typedef struct packed {
        logic [15:0] mem_address;
        logic        mem_write_enable;
        logic        mem_read_enable;
        logic [7:0]  mem_write_data;
        logic        busy_res;
        logic        done_res;
        logic        test_error;
    } t_out_item;

    function automatic t_ctrl ucode(input t_step s);
        t_ctrl c;
        c = '0;
        case (s)
            STEP_SAVE: begin
                c.op = OP_READ;   c.capture = 1'b1; c.next = STEP_M0;
            end
            STEP_M0: begin
                c.op = OP_WRITE;  c.wdata = PAT_ZERO; c.next = STEP_M1;
            end
            STEP_M1: begin
                c.op = OP_READ;   c.expected = PAT_ZERO; c.wdata = PAT_ONES;
                c.rmw = 1'b1;     c.next = STEP_M2;
            end
            STEP_M2: begin
                c.op = OP_READ;   c.expected = PAT_ONES; c.wdata = PAT_ZERO;
                c.rmw = 1'b1;     c.next = STEP_M3;
            end
            STEP_M3: begin
                c.op = OP_READ;   c.expected = PAT_ZERO; c.wdata = PAT_ONES;
                c.rmw = 1'b1;     c.desc = 1'b1; c.next = STEP_M4;
            end
            STEP_M4: begin
                c.op = OP_READ;   c.expected = PAT_ONES; c.wdata = PAT_ZERO;
                c.rmw = 1'b1;     c.desc = 1'b1; c.next = STEP_M5;
            end
            STEP_M5: begin
                c.op = OP_READ;   c.expected = PAT_ZERO; c.desc = 1'b1;
                c.next = STEP_RESTORE; c.alt = STEP_FINISH; c.alt_no_save = 1'b1;
            end
            STEP_RESTORE: begin
                c.op = OP_WRITE;  c.use_buf = 1'b1; c.next = STEP_FINISH;
            end
            default: begin
                c = '0;
            end
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/mct_stream_if.sv -----
// Valid/ready stream channel carrying one payload beat.
interface mct_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/mct_save_buffer.sv -----
// Save buffer RAM: one write port, one registered read port.
module mct_save_buffer #(
    parameter int DEPTH = 256,
    parameter int IW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [IW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/mct_sequencer.sv -----
// Microcoded March C sequencer: step counter, position counter and compare datapath.
module mct_sequencer
    import mct_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256,
    parameter int ADDRESS_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    localparam int IW = $clog2(BUFFER_DEPTH);
    localparam int PW = $clog2(BUFFER_DEPTH + 1);
    localparam int CW = (PW > 9) ? PW : 9;

    typedef struct packed {
        t_step         step;
        logic [PW-1:0] pos;
    } t_cursor;

    t_step         r_step, n_step;
    logic [PW-1:0] r_pos, n_pos;
    logic          r_pend, n_pend;
    logic          r_mis, n_mis;
    logic [15:0]   r_run_base, n_run_base;
    logic [PW-1:0] r_run_len, n_run_len;
    logic          r_run_save, n_run_save;

    logic          buf_we;
    logic [7:0]    buf_rdata;
    t_out_item     res;

    // Step to the next position, or into the next step at the end of the region
    function automatic t_cursor advance(input t_cursor c, input logic [PW-1:0] len,
                                        input logic save);
        t_ctrl   cw;
        t_ctrl   nw;
        t_step   tgt;
        t_cursor r;
        logic    at_end;
        cw = ucode(c.step);
        r  = c;
        at_end = cw.desc ? (c.pos == '0) : (PW'(c.pos + PW'(1)) >= len);
        if (at_end) begin
            tgt    = (cw.alt_no_save && !save) ? cw.alt : cw.next;
            nw     = ucode(tgt);
            r.step = tgt;
            r.pos  = nw.desc ? PW'(len - PW'(1)) : '0;
        end else begin
            r.pos  = cw.desc ? PW'(c.pos - PW'(1)) : PW'(c.pos + PW'(1));
        end
        return r;
    endfunction

    function automatic logic [15:0] addr_of(input logic [15:0] base, input logic [PW-1:0] pos);
        logic [ADDRESS_BITS-1:0] a;
        a = ADDRESS_BITS'(ADDRESS_BITS'(base) + ADDRESS_BITS'(pos));
        return 16'(a);
    endfunction

    // Clamp the requested length to 1 .. BUFFER_DEPTH
    function automatic logic [PW-1:0] clamp_len(input logic [8:0] len);
        logic [CW-1:0] lx;
        lx = CW'(len);
        if (lx == '0) begin
            lx = CW'(1);
        end
        if (lx > CW'(BUFFER_DEPTH)) begin
            lx = CW'(BUFFER_DEPTH);
        end
        return PW'(lx);
    endfunction

    always_comb begin
        t_cursor       cur;
        t_ctrl         cw;
        t_ctrl         cw2;
        logic          do_issue;
        cur        = '{step: r_step, pos: r_pos};
        n_run_len  = r_run_len;
        n_run_save = r_run_save;
        n_run_base = r_run_base;
        n_pend     = r_pend;
        n_mis      = r_mis;
        res        = '0;
        buf_we     = 1'b0;
        do_issue   = 1'b0;
        cw         = ucode(r_step);
        cw2        = '0;

        if (i_fire) begin
            case (r_step)
                STEP_IDLE: begin
                    if (i_item.start_req) begin
                        n_run_len  = clamp_len(i_cfg.region_length);
                        n_run_save = i_cfg.save_restore;
                        n_run_base = i_cfg.base_address;
                        n_mis      = 1'b0;
                        n_pend     = 1'b0;
                        cur.step   = i_cfg.save_restore ? STEP_SAVE : STEP_M0;
                        cur.pos    = '0;
                        res.busy_res = 1'b1;
                        do_issue   = 1'b1;
                    end
                end
                STEP_FINISH: begin
                    res.done_res = 1'b1;
                    cur.step     = STEP_IDLE;
                    cur.pos      = '0;
                    n_pend       = 1'b0;
                end
                default: begin
                    res.busy_res = 1'b1;
                    if (r_pend) begin
                        n_pend = 1'b0;
                        if (cw.capture) begin
                            buf_we = 1'b1;
                        end else begin
                            if (i_item.read_data != cw.expected) begin
                                n_mis = 1'b1;
                            end
                            if (cw.rmw) begin
                                res.mem_write_enable = 1'b1;
                                res.mem_address      = addr_of(n_run_base, cur.pos);
                                res.mem_write_data   = cw.wdata;
                            end
                        end
                        cur      = advance(cur, n_run_len, n_run_save);
                        do_issue = !cw.rmw;
                    end else begin
                        do_issue = 1'b1;
                    end
                end
            endcase

            // Issue the access of the step now in effect
            if (do_issue) begin
                cw2 = ucode(cur.step);
                case (cw2.op)
                    OP_READ: begin
                        res.mem_read_enable = 1'b1;
                        res.mem_address     = addr_of(n_run_base, cur.pos);
                        n_pend              = 1'b1;
                    end
                    OP_WRITE: begin
                        res.mem_write_enable = 1'b1;
                        res.mem_address      = addr_of(n_run_base, cur.pos);
                        res.mem_write_data   = cw2.use_buf ? buf_rdata : cw2.wdata;
                        cur                  = advance(cur, n_run_len, n_run_save);
                    end
                    default: begin
                        res.mem_address = '0;
                    end
                endcase
            end
        end

        res.test_error = n_mis;
        n_step         = cur.step;
        n_pos          = cur.pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
            r_pos  <= '0;
            r_pend <= 1'b0;
            r_mis  <= 1'b0;
        end else begin
            r_step <= n_step;
            r_pos  <= n_pos;
            r_pend <= n_pend;
            r_mis  <= n_mis;
        end
        r_run_base <= n_run_base;
        r_run_len  <= n_run_len;
        r_run_save <= n_run_save;
    end

    // Read port follows the next position, so buf_rdata always holds the entry at r_pos
    mct_save_buffer #(
        .DEPTH (BUFFER_DEPTH),
        .IW    (IW)
    ) u_save_buffer (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (r_pos[IW-1:0]),
        .i_wdata (i_item.read_data),
        .i_raddr (n_pos[IW-1:0]),
        .o_rdata (buf_rdata)
    );

    assign o_result = res;

endmodule

// ----- hdl/march_c_memory_test.sv -----
// Top level of the March C memory self-test controller.
//
// Usage:
//   i_item carries one beat per memory clock tick: start_req and the read_data
//   byte returned for the read issued in the previous result beat.
//   o_result carries exactly one beat per input beat: the memory access for
//   that tick (address, read/write enables, write data) plus busy, done and
//   the sticky test_error flag, which is meaningful on the done beat.
//   The configuration port (i_cfg_we, i_cfg_index, i_cfg_data) sets
//   base_address, region_length and save_restore; a write takes effect at
//   the next start.
// A result beat is registered and appears in the cycle after its input beat.
//   Throughput: one beat per cycle unless the receiver stalls; the step and
//   position counters and the microcode lookup settle within that cycle.
// A test over n bytes runs M0..M5, with n save reads before them and n
//   restore writes after them when save/restore is on; M1..M4 read and then
//   write each byte, M0 only writes and M5 only reads.
// Reset clears the sequencer to idle and the output register to empty; the
//   save buffer is not cleared, since a restore only reads what the same run
//   saved.
// When the receiver stalls, the held result stays on o_result and i_item is
//   not taken until the output register frees up.
module march_c_memory_test
    import mct_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256,
    parameter int ADDRESS_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    mct_stream_if.sink    i_item,
    mct_stream_if.source  o_result
);

    t_cfg      r_cfg;
    logic      r_out_valid;
    t_out_item r_out_data;
    t_out_item seq_result;
    logic      in_ready;
    logic      fire;

    // Take a new beat whenever the output register is empty or draining
    assign in_ready     = !r_out_valid || o_result.ready;
    assign fire         = i_item.valid && in_ready;
    assign i_item.ready = in_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_address  <= 16'd0;
            r_cfg.region_length <= 9'd256;
            r_cfg.save_restore  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BASE_ADDRESS:  r_cfg.base_address  <= i_cfg_data;
                CFG_REGION_LENGTH: r_cfg.region_length <= i_cfg_data[8:0];
                CFG_SAVE_RESTORE:  r_cfg.save_restore  <= i_cfg_data[0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    mct_sequencer #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_sequencer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (i_item.data),
        .i_cfg    (r_cfg),
        .o_result (seq_result)
    );

    // Output register: load on an accepted beat, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
        if (fire) begin
            r_out_data <= seq_result;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out_data;

endmodule

// ----- hdl/mct_checker.sv -----
// Port-level checks of the March C test controller and their bind.
module mct_checker
    import mct_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    a_one_access_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_data.mem_write_enable && i_out_data.mem_read_enable))
        else $error("read and write issued on the same beat");

    a_idle_bus_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_data.mem_write_enable && !i_out_data.mem_read_enable)
        |-> (i_out_data.mem_address == 16'd0 && i_out_data.mem_write_data == 8'd0))
        else $error("address or data driven on a beat with no access");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.done_res) |-> !i_out_data.busy_res)
        else $error("done reported while busy");

    a_access_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_data.mem_write_enable || i_out_data.mem_read_enable))
        |-> i_out_data.busy_res)
        else $error("memory access outside a running test");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("result beat changed while stalled");

endmodule

bind march_c_memory_test mct_checker u_mct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_data  (o_result.data)
);
